[src/differential_drive_odometry_unit_defines.svh]
// shared assertion macros for the odometry block
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH

// same-cycle implication, idle during reset
`define DDO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ddo_pkg.sv]
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 24;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_MPT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IWB = 1'd1;

  localparam logic [31:0] MPT_RESET = 32'd5987952;
  localparam logic [31:0] IWB_RESET = 32'd44150568;

  // multiplier and divider sizes
  localparam int unsigned MUL_AW = 64;
  localparam int unsigned MUL_BW = 32;
  localparam int unsigned NUM_W  = 61;
  localparam int unsigned US_W   = 24;

  localparam logic signed [33:0] PI_Q29       = 34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q29   = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q29  = 34'sd843314857;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] UNIT_Q30     = 34'sd1073741824;
  localparam logic [31:0]        US_PER_S     = 32'd1000000;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [23:0]        elapsed_us;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_speed;
  } out_t;

  // arctangent of 2^-i in Q3.29
  function automatic logic [31:0] atan_q29(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd421657428;
      5'd1: v = 32'd248918915;
      5'd2: v = 32'd131521918;
      5'd3: v = 32'd66762579;
      5'd4: v = 32'd33510843;
      5'd5: v = 32'd16771758;
      5'd6: v = 32'd8387925;
      5'd7: v = 32'd4194219;
      5'd8: v = 32'd2097141;
      5'd9: v = 32'd1048575;
      5'd30, 5'd31: v = 32'd0;
      default: v = 32'd1 << (5'd29 - i);
    endcase
    return v;
  endfunction

endpackage

[src/ddo_smul.sv]
module ddo_smul #(
  parameter int unsigned AW = ddo_pkg::MUL_AW,
  parameter int unsigned BW = ddo_pkg::MUL_BW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] prod
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc;
  logic [AW-1:0]    mcand;
  logic [CW-1:0]    cnt;
  logic [AW:0]      sum;

  // one multiplier bit per cycle, lsb first
  assign sum  = {1'b0, acc[AW+BW-1:BW]} + (acc[0] ? {1'b0, mcand} : {(AW+1){1'b0}});
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(BW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {{AW{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      acc <= {sum, acc[BW-1:1]};
    end
  end

endmodule

[src/ddo_sdiv.sv]
module ddo_sdiv #(
  parameter int unsigned NW = ddo_pkg::NUM_W,
  parameter int unsigned DW = ddo_pkg::US_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem, q[NW-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = rem_sh >= {1'b0, dvs};
  assign quot   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= den;
      q   <= num;
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
      q   <= {q[NW-2:0], fits};
    end
  end

endmodule

[src/ddo_cordic.sv]
module ddo_cordic #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  output logic               busy,
  output logic signed [31:0] cos_v,
  output logic signed [31:0] sin_v
);

  localparam int unsigned IW = $clog2(CORDIC_STEPS);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic signed [33:0] z0;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic [IW-1:0]      idx;

  assign z0 = {{2{angle[31]}}, angle};
  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = $signed({2'b00, ddo_pkg::atan_q29(5'(idx))});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy) begin
      if (idx == IW'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // fold into the right half plane by a quarter turn
      if (z0 > ddo_pkg::HALF_PI_Q29) begin
        x <= '0;
        y <= ddo_pkg::CORDIC_START;
        z <= z0 - ddo_pkg::HALF_PI_Q29;
      end else if (z0 < -ddo_pkg::HALF_PI_Q29) begin
        x <= '0;
        y <= -ddo_pkg::CORDIC_START;
        z <= z0 + ddo_pkg::HALF_PI_Q29;
      end else begin
        x <= ddo_pkg::CORDIC_START;
        y <= '0;
        z <= z0;
      end
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  always_comb begin
    if (x > ddo_pkg::UNIT_Q30) begin
      cos_v = 32'(ddo_pkg::UNIT_Q30);
    end else if (x < -ddo_pkg::UNIT_Q30) begin
      cos_v = 32'(-ddo_pkg::UNIT_Q30);
    end else begin
      cos_v = x[31:0];
    end
    if (y > ddo_pkg::UNIT_Q30) begin
      sin_v = 32'(ddo_pkg::UNIT_Q30);
    end else if (y < -ddo_pkg::UNIT_Q30) begin
      sin_v = 32'(-ddo_pkg::UNIT_Q30);
    end else begin
      sin_v = y[31:0];
    end
  end

endmodule

[src/differential_drive_odometry_unit.sv]
// differential-drive wheel odometry. each input item carries both encoder
// counts and the microseconds since the previous item; each produces one
// result item with the new pose (x, y in q16.16 meters, saturating; heading
// in q3.29 radians wrapped to plus or minus pi) and the linear and angular
// speed in q16.16 (zero when the elapsed time is zero). wheel deltas are
// |new count| - |old count|. an item passes from accept to result through
// four passes through the pair of bit-serial 64x32 multipliers (start, 32
// bit steps, done), one pass through the two bit-serial 61/24 speed
// dividers (start, 61 bit steps, done) and 11 further steps, the cordic
// running under the first multiplier pass. the next item is taken only once
// the result is loaded and the sequencer is back in idle; a stalled output
// holds the sequencer in its last step. a finished result sits in the
// output register while the next item is accepted. configuration writes take
// effect at once and must only be issued while the block is idle.
module differential_drive_odometry_unit #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ddo_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ddo_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned PW = ddo_pkg::MUL_AW + ddo_pkg::MUL_BW;

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DLT  = 5'd1;
  localparam logic [4:0] ST_M1   = 5'd2;
  localparam logic [4:0] ST_P0   = 5'd3;
  localparam logic [4:0] ST_P1   = 5'd4;
  localparam logic [4:0] ST_P2   = 5'd5;
  localparam logic [4:0] ST_M2   = 5'd6;
  localparam logic [4:0] ST_P3   = 5'd7;
  localparam logic [4:0] ST_H1   = 5'd8;
  localparam logic [4:0] ST_H2   = 5'd9;
  localparam logic [4:0] ST_M3   = 5'd10;
  localparam logic [4:0] ST_P4   = 5'd11;
  localparam logic [4:0] ST_M4   = 5'd12;
  localparam logic [4:0] ST_P5   = 5'd13;
  localparam logic [4:0] ST_DIV  = 5'd14;
  localparam logic [4:0] ST_FIN  = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  logic [4:0]  state;
  logic        fresh;

  // configuration
  logic [31:0] mpt;
  logic [31:0] iwb;

  // architectural state: only the magnitudes of the old counts matter
  logic [31:0]        prevl;
  logic [31:0]        prevr;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_h;

  // per-item working registers
  logic [31:0]        absl;
  logic [31:0]        absr;
  logic [23:0]        us;
  logic               dl_neg;
  logic               dr_neg;
  logic [31:0]        dl_mag;
  logic [31:0]        dr_mag;
  logic [64:0]        dl32;
  logic [64:0]        dr32;
  logic [48:0]        travel;
  logic [57:0]        diff;
  logic               tr_neg;
  logic [48:0]        tr_mag;
  logic               diff_neg;
  logic [57:0]        diff_mag;
  logic [40:0]        mag16;
  logic [31:0]        dth;
  logic [33:0]        xstep;
  logic [33:0]        ystep;
  logic [33:0]        hsum;
  logic [60:0]        lin_num;
  logic [60:0]        ang_num;
  logic [31:0]        lin;
  logic [31:0]        ang;

  // shared unit hookup
  logic               mul_start;
  logic [63:0]        mula_a;
  logic [31:0]        mula_b;
  logic [63:0]        mulb_a;
  logic [31:0]        mulb_b;
  logic               mula_busy;
  logic               mulb_busy;
  logic [PW-1:0]      mula_prod;
  logic [PW-1:0]      mulb_prod;
  logic               cor_busy;
  logic signed [31:0] cos_v;
  logic signed [31:0] sin_v;
  logic               c_neg;
  logic               s_neg;
  logic [31:0]        c_mag;
  logic [31:0]        s_mag;
  logic               div_start;
  logic               diva_busy;
  logic               divb_busy;
  logic [60:0]        diva_q;
  logic [60:0]        divb_q;
  logic               busy_any;
  logic               unit_done;

  // combinational helpers
  logic [32:0]        tc_mag;
  logic [40:0]        tv_mag;
  logic [32:0]        dlraw;
  logic [32:0]        drraw;
  logic [64:0]        pl_ext;
  logic [64:0]        pr_ext;
  logic [49:0]        tr_sum;
  logic [30:0]        mag29;
  logic [63:0]        mag_hi;
  logic [63:0]        xp;
  logic [63:0]        yp;
  logic [34:0]        xsum;
  logic [34:0]        ysum;
  logic               in_acc;
  logic               out_load;
  ddo_pkg::out_t      res;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  assign c_neg = cos_v[31];
  assign s_neg = sin_v[31];
  assign c_mag = c_neg ? (32'd0 - cos_v) : cos_v;
  assign s_mag = s_neg ? (32'd0 - sin_v) : sin_v;

  // travel clamped for the position step and for the speed
  assign tc_mag = (tr_mag > 49'h1_0000_0000) ? 33'h1_0000_0000 : tr_mag[32:0];
  assign tv_mag = (tr_mag > 49'h100_0000_0000) ? 41'h100_0000_0000 : tr_mag[40:0];

  assign dlraw  = {1'b0, absl} - {1'b0, prevl};
  assign drraw  = {1'b0, absr} - {1'b0, prevr};
  assign pl_ext = {1'b0, mula_prod[63:0]};
  assign pr_ext = {1'b0, mulb_prod[63:0]};
  assign tr_sum = {dl32[64], dl32[64:16]} + {dr32[64], dr32[64:16]};

  // heading change saturates at 2^31-1 in q3.29
  assign mag29  = (|mula_prod[PW-1:50]) ? 31'h7FFF_FFFF : mula_prod[49:19];
  assign mag_hi = mula_prod[PW-1:32];

  assign xp   = (tr_neg ^ c_neg) ? (64'd0 - {1'b0, mulb_prod[62:0]}) : {1'b0, mulb_prod[62:0]};
  assign yp   = (tr_neg ^ s_neg) ? (64'd0 - {1'b0, mula_prod[62:0]}) : {1'b0, mula_prod[62:0]};
  assign xsum = {{3{acc_x[31]}}, acc_x} + {xstep[33], xstep};
  assign ysum = {{3{acc_y[31]}}, acc_y} + {ystep[33], ystep};

  assign busy_any  = mula_busy || mulb_busy || cor_busy || diva_busy || divb_busy;
  assign unit_done = !fresh && !busy_any;
  assign mul_start = fresh && (state == ST_M1 || state == ST_M2 || state == ST_M3 ||
                               state == ST_M4);
  assign div_start = fresh && (state == ST_DIV);
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    mula_a = '0;
    mula_b = '0;
    mulb_a = '0;
    mulb_b = '0;
    case (state)
      ST_M1: begin
        mula_a = {32'd0, dl_mag};
        mula_b = mpt;
        mulb_a = {32'd0, dr_mag};
        mulb_b = mpt;
      end
      ST_M2: begin
        mula_a = {6'd0, diff_mag};
        mula_b = iwb;
        mulb_a = {31'd0, tc_mag};
        mulb_b = c_mag;
      end
      ST_M3: begin
        mula_a = {31'd0, tc_mag};
        mula_b = s_mag;
        mulb_a = {23'd0, tv_mag};
        mulb_b = ddo_pkg::US_PER_S;
      end
      ST_M4: begin
        mula_a = {23'd0, mag16};
        mula_b = ddo_pkg::US_PER_S;
      end
      default: begin
      end
    endcase
  end

  // magnitude quotient to saturated signed speed
  function automatic logic [31:0] sat_speed(input logic [60:0] q, input logic neg);
    logic [31:0] v;
    if (!neg) begin
      v = (|q[60:31]) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      v = (|q[60:31]) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end
    return v;
  endfunction

  function automatic logic [31:0] sat35(input logic [34:0] v);
    logic [31:0] r;
    if (v[34] && !(&v[33:31])) begin
      r = 32'h8000_0000;
    end else if (!v[34] && (|v[33:31])) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mpt <= ddo_pkg::MPT_RESET;
      iwb <= ddo_pkg::IWB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ddo_pkg::REG_MPT: mpt <= cfg_data;
        ddo_pkg::REG_IWB: iwb <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fresh <= 1'b0;
      prevl <= '0;
      prevr <= '0;
      acc_x <= '0;
      acc_y <= '0;
      acc_h <= '0;
    end else begin
      fresh <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_DLT;
            fresh <= 1'b1;
          end
        end
        ST_DLT: begin
          prevl <= absl;
          prevr <= absr;
          state <= ST_M1;
          fresh <= 1'b1;
        end
        ST_M1: begin
          if (unit_done) begin
            state <= ST_P0;
            fresh <= 1'b1;
          end
        end
        ST_P0: begin
          state <= ST_P1;
          fresh <= 1'b1;
        end
        ST_P1: begin
          state <= ST_P2;
          fresh <= 1'b1;
        end
        ST_P2: begin
          state <= ST_M2;
          fresh <= 1'b1;
        end
        ST_M2: begin
          if (unit_done) begin
            state <= ST_P3;
            fresh <= 1'b1;
          end
        end
        ST_P3: begin
          state <= ST_H1;
          fresh <= 1'b1;
        end
        ST_H1: begin
          acc_x <= sat35(xsum);
          state <= ST_H2;
          fresh <= 1'b1;
        end
        ST_H2: begin
          // wrap once into plus or minus pi
          if ($signed(hsum) > ddo_pkg::PI_Q29) begin
            acc_h <= 32'($signed(hsum) - ddo_pkg::TWO_PI_Q29);
          end else if ($signed(hsum) < -ddo_pkg::PI_Q29) begin
            acc_h <= 32'($signed(hsum) + ddo_pkg::TWO_PI_Q29);
          end else begin
            acc_h <= hsum[31:0];
          end
          state <= ST_M3;
          fresh <= 1'b1;
        end
        ST_M3: begin
          if (unit_done) begin
            state <= ST_P4;
            fresh <= 1'b1;
          end
        end
        ST_P4: begin
          state <= ST_M4;
          fresh <= 1'b1;
        end
        ST_M4: begin
          if (fresh) begin
            acc_y <= sat35(ysum);
          end
          if (unit_done) begin
            state <= ST_P5;
            fresh <= 1'b1;
          end
        end
        ST_P5: begin
          state <= ST_DIV;
          fresh <= 1'b1;
        end
        ST_DIV: begin
          if (unit_done) begin
            state <= ST_FIN;
            fresh <= 1'b1;
          end
        end
        ST_FIN: begin
          state <= ST_OUT;
          fresh <= 1'b1;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
            fresh <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          absl <= in_data.left_count[31] ? (32'd0 - in_data.left_count) : in_data.left_count;
          absr <= in_data.right_count[31] ? (32'd0 - in_data.right_count)
                                          : in_data.right_count;
          us   <= in_data.elapsed_us;
        end
      end
      ST_DLT: begin
        dl_neg <= dlraw[32];
        dr_neg <= drraw[32];
        dl_mag <= dlraw[32] ? 32'(33'd0 - dlraw) : dlraw[31:0];
        dr_mag <= drraw[32] ? 32'(33'd0 - drraw) : drraw[31:0];
      end
      ST_P0: begin
        dl32 <= dl_neg ? (65'd0 - pl_ext) : pl_ext;
        dr32 <= dr_neg ? (65'd0 - pr_ext) : pr_ext;
      end
      ST_P1: begin
        travel <= tr_sum[49:1];
        diff   <= {dr32[64], dr32[64:8]} - {dl32[64], dl32[64:8]};
      end
      ST_P2: begin
        tr_neg   <= travel[48];
        tr_mag   <= travel[48] ? (49'd0 - travel) : travel;
        diff_neg <= diff[57];
        diff_mag <= diff[57] ? (58'd0 - diff) : diff;
      end
      ST_P3: begin
        dth   <= diff_neg ? (32'd0 - {1'b0, mag29}) : {1'b0, mag29};
        mag16 <= (mag_hi > 64'h100_0000_0000) ? 41'h100_0000_0000 : mag_hi[40:0];
        xstep <= xp[63:30];
      end
      ST_H1: begin
        hsum <= {{2{acc_h[31]}}, acc_h} + {{2{dth[31]}}, dth};
      end
      ST_P4: begin
        ystep   <= yp[63:30];
        lin_num <= mulb_prod[60:0];
      end
      ST_P5: begin
        ang_num <= mula_prod[60:0];
      end
      ST_FIN: begin
        lin <= (us == 24'd0) ? 32'd0 : sat_speed(diva_q, tr_neg);
        ang <= (us == 24'd0) ? 32'd0 : sat_speed(divb_q, diff_neg);
      end
      default: begin
      end
    endcase
  end

  assign res.pos_x         = acc_x;
  assign res.pos_y         = acc_y;
  assign res.heading       = acc_h;
  assign res.linear_speed  = lin;
  assign res.angular_speed = ang;

  // output register: holds a finished item while the next one is worked on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  ddo_smul #(
    .AW(ddo_pkg::MUL_AW),
    .BW(ddo_pkg::MUL_BW)
  ) u_mula (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mula_a),
    .b    (mula_b),
    .busy (mula_busy),
    .prod (mula_prod)
  );

  ddo_smul #(
    .AW(ddo_pkg::MUL_AW),
    .BW(ddo_pkg::MUL_BW)
  ) u_mulb (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mulb_a),
    .b    (mulb_b),
    .busy (mulb_busy),
    .prod (mulb_prod)
  );

  // cosine and sine of the old heading, run during the first multiply pass
  ddo_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start && (state == ST_M1)),
    .angle(acc_h),
    .busy (cor_busy),
    .cos_v(cos_v),
    .sin_v(sin_v)
  );

  ddo_sdiv #(
    .NW(ddo_pkg::NUM_W),
    .DW(ddo_pkg::US_W)
  ) u_diva (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (lin_num),
    .den  (us),
    .busy (diva_busy),
    .quot (diva_q)
  );

  ddo_sdiv #(
    .NW(ddo_pkg::NUM_W),
    .DW(ddo_pkg::US_W)
  ) u_divb (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (ang_num),
    .den  (us),
    .busy (divb_busy),
    .quot (divb_q)
  );

endmodule

[src/ddo_chk.sv]
`include "differential_drive_odometry_unit_defines.svh"

module ddo_chk (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ddo_pkg::out_t out_data
);

  `DDO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled item changed")
  `DDO_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a second item too early")
  `DDO_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "result one cycle after accept")
  `DDO_ASSERT_NOW(a_heading_range, out_valid, (out_data.heading <= 32'sd1686629713) && (out_data.heading >= -32'sd1686629713), "heading outside plus or minus pi")

endmodule

bind differential_drive_odometry_unit ddo_chk u_ddo_chk (.*);
